// File: src/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg
// shared constants, register indexes and helpers of the substring search
// ----------------------------------------------------------------------------
package wss_pkg;

  localparam int BYTE_W      = 8;
  localparam int PAT_BYTES   = 8;
  localparam int PAT_W       = BYTE_W * PAT_BYTES;
  localparam int LEN_W       = 4;
  localparam int WIN_W       = 16;
  localparam int IDX_W       = 16;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = PAT_W;

  localparam int MAX_PATTERN_DEF = 8;
  localparam int MAX_TEXT_DEF    = 65536;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_BYTES  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_LENGTH = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SEARCH_BEGIN   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SEARCH_END     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SEARCH_MODE    = 3'd4;

  typedef enum logic {
    MODE_FIRST = 1'b0,
    MODE_LAST  = 1'b1
  } mode_e;

  // pattern length in use: zero acts as one, clipped to the cell count
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len,
                                                 input int unsigned   max_len);
    logic [LEN_W-1:0] n;
    n = len;
    if (n == '0) begin
      n = LEN_W'(1);
    end
    if (n > LEN_W'(max_len)) begin
      n = LEN_W'(max_len);
    end
    return n;
  endfunction

  // pattern byte that the history cell at position idx must equal
  function automatic logic [BYTE_W-1:0] pat_byte_for(input logic [PAT_W-1:0] pat,
                                                     input logic [LEN_W-1:0] plen,
                                                     input logic [LEN_W-1:0] idx);
    logic [LEN_W-1:0] sel;
    sel = plen - idx - LEN_W'(1);
    return pat[{sel[2:0], 3'b000} +: BYTE_W];
  endfunction

endpackage

// File: src/windowed_substring_search.sv
// ----------------------------------------------------------------------------
// windowed_substring_search
// streaming search of a text for a pattern of up to eight bytes in a window
// ----------------------------------------------------------------------------
// Text bytes enter one per transfer on the slave stream, tlast marking the
// final byte. A chain of MaxPattern cells holds the most recent bytes; each
// cell compares the byte it takes in against its pattern byte, so a match is
// seen on the byte that completes it. A decision stage keeps the first match
// start inside [search_begin, search_end) in first mode, or the start of the
// match ending latest inside [search_begin, search_end] in last mode. On the
// final byte one result transfer carries found and match_index (0 when not
// found); it is not found if search_begin or search_end is not below the text
// length or the pattern is longer than the text, and bytes past MaxText are
// not searched. The block takes one byte every cycle while the input is not
// stalled. The final byte passes the decision stage register and then the
// output register before its result appears on the master stream. Input
// stalls only while a result is waiting on the master stream and the next
// final byte has reached the decision stage. The user must write the
// configuration only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module windowed_substring_search import wss_pkg::*; #(
  parameter int MaxPattern = MAX_PATTERN_DEF,
  parameter int MaxText    = MAX_TEXT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // text stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] text_byte
  input  logic                  s_axis_tlast,   // is_last
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [IDX_W-1:0]      m_axis_tdata,   // [15:0] match_index
  output logic                  m_axis_tuser    // [0] found
);

  localparam int PosW = $clog2(MaxText + 1);
  localparam int CmpW = (PosW + 1 > WIN_W) ? PosW + 1 : WIN_W;

  // decision stage item
  typedef struct packed {
    logic            last;
    logic            in_range;
    logic [PosW-1:0] pos;
  } s1_t;

  // configuration registers
  logic [PAT_W-1:0] pattern_q;
  logic [LEN_W-1:0] len_q;
  logic [WIN_W-1:0] begin_q;
  logic [WIN_W-1:0] end_q;
  mode_e            mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      len_q     <= LEN_W'(1);
      begin_q   <= '0;
      end_q     <= '0;
      mode_q    <= MODE_FIRST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_PATTERN_BYTES:  pattern_q <= cfg_wdata_i[PAT_W-1:0];
        REG_PATTERN_LENGTH: len_q     <= cfg_wdata_i[LEN_W-1:0];
        REG_SEARCH_BEGIN:   begin_q   <= cfg_wdata_i[WIN_W-1:0];
        REG_SEARCH_END:     end_q     <= cfg_wdata_i[WIN_W-1:0];
        REG_SEARCH_MODE:    mode_q    <= mode_e'(cfg_wdata_i[0]);
        default: ;
      endcase
    end
  end

  logic [LEN_W-1:0] plen;
  assign plen = clamp_len(len_q, MaxPattern);

  // handshake and pipeline control
  logic s_fire;
  logic stall;
  logic out_free;
  logic s1_valid_q;
  s1_t  s1_q, s1_d;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  // only a final byte in the decision stage needs the output register
  assign stall         = s1_valid_q && s1_q.last && !out_free;
  assign s_axis_tready = !stall;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // text position counter, saturates at MaxText
  logic [PosW-1:0] pos_q, pos_d;
  logic            in_range0;

  assign in_range0 = (pos_q < PosW'(MaxText));

  always_comb begin
    pos_d = pos_q;
    if (s_fire) begin
      if (s_axis_tlast) begin
        pos_d = '0;
      end else if (in_range0) begin
        pos_d = pos_q + PosW'(1);
      end
    end
    s1_d.last     = s_axis_tlast;
    s1_d.in_range = in_range0;
    s1_d.pos      = pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (!stall) begin
        s1_valid_q <= s_fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_q <= s1_d;
    end
  end

  // chain of history cells, newest byte in cell 0
  logic [BYTE_W-1:0]     chain [MaxPattern+1];
  logic [MaxPattern-1:0] eq_q;

  assign chain[0] = s_axis_tdata;

  for (genvar g = 0; g < MaxPattern; g++) begin : g_cell
    wss_cell #(
      .Idx (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (s_fire),
      .clear_i   (s_axis_tlast),
      .data_i    (chain[g]),
      .pattern_i (pattern_q),
      .plen_i    (plen),
      .data_o    (chain[g+1]),
      .eq_o      (eq_q[g])
    );
  end

  // decision stage
  logic [MaxPattern-1:0] use_mask;
  logic [CmpW-1:0]       pos_c, pos1_c, plen_c, start_c, begin_c, end_c, text_len_c;
  logic                  hit, take, have_upd, found;
  logic [IDX_W-1:0]      best_upd;
  logic                  have_q, have_d;
  logic [IDX_W-1:0]      best_q, best_d;
  logic                  advance;

  always_comb begin
    for (int j = 0; j < MaxPattern; j++) begin
      use_mask[j] = (LEN_W'(j) < plen);
    end
    pos_c      = CmpW'(s1_q.pos);
    pos1_c     = pos_c + CmpW'(1);
    plen_c     = CmpW'(plen);
    start_c    = pos1_c - plen_c;
    begin_c    = CmpW'(begin_q);
    end_c      = CmpW'(end_q);
    text_len_c = s1_q.in_range ? pos1_c : CmpW'(MaxText);

    hit = s1_q.in_range && (&(eq_q | ~use_mask)) && (pos1_c >= plen_c);
    if (mode_q == MODE_FIRST) begin
      take = !have_q && (start_c >= begin_c) && (start_c < end_c);
    end else begin
      take = (pos_c >= begin_c) && (pos_c <= end_c);
    end

    have_upd = have_q || (hit && take);
    best_upd = (hit && take) ? start_c[IDX_W-1:0] : best_q;
    found    = have_upd && (begin_c < text_len_c) && (end_c < text_len_c) &&
               (plen_c <= text_len_c);

    advance = s1_valid_q && !stall;
    have_d  = have_q;
    best_d  = best_q;
    if (advance) begin
      // final byte returns the stream state to reset
      have_d = s1_q.last ? 1'b0 : have_upd;
      best_d = s1_q.last ? '0   : best_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      best_q <= '0;
    end else begin
      have_q <= have_d;
      best_q <= best_d;
    end
  end

  // output register
  logic             out_valid_q, out_valid_d;
  logic             out_found_q;
  logic [IDX_W-1:0] out_idx_q;
  logic             out_load;

  assign out_load = advance && s1_q.last;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q <= found;
      out_idx_q   <= found ? best_upd : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_idx_q;
  assign m_axis_tuser  = out_found_q;

`ifndef SYNTHESIS
  // input backs up only behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a blocked result");

  // a not-found result carries a zero index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("not-found result with nonzero index");

  // the final byte restarts the position count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tlast) |=> (pos_q == '0))
    else $error("position not cleared after final byte");
`endif

endmodule

// File: src/wss_cell.sv
// ----------------------------------------------------------------------------
// wss_cell
// one history byte of the text shift chain with its pattern comparator
// ----------------------------------------------------------------------------
module wss_cell import wss_pkg::*; #(
  parameter int Idx = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              clear_i,
  input  logic [BYTE_W-1:0] data_i,
  input  logic [PAT_W-1:0]  pattern_i,
  input  logic [LEN_W-1:0]  plen_i,
  output logic [BYTE_W-1:0] data_o,
  output logic              eq_o
);

  localparam logic [LEN_W-1:0] IdxV = LEN_W'(Idx);

  logic [BYTE_W-1:0] data_q, data_d;
  logic              eq_q, eq_d;

  always_comb begin
    eq_d   = (data_i == pat_byte_for(pattern_i, plen_i, IdxV));
    // end of text empties the history
    data_d = clear_i ? '0 : data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (en_i) begin
      data_q <= data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      eq_q <= eq_d;
    end
  end

  assign data_o = data_q;
  assign eq_o   = eq_q;

endmodule

// File: tb/tb_windowed_substring_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_windowed_substring_search
// self-checking bench for the streaming windowed substring search
// ----------------------------------------------------------------------------
// A tracker object mirrors the search in software: it keeps its own copy of
// the registers, the byte history and the best match so far, and queues one
// verdict for every text that ends. Each result transfer is compared field by
// field against the oldest queued verdict. The stimulus covers a short set
// of hand-made texts, random register settings with texts that carry planted
// copies of the pattern, and a long stall of the result side. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------
module tb_windowed_substring_search import wss_pkg::*; ();

  localparam int CLK_HALF    = 4;
  localparam int RST_CYCLES  = 4;
  localparam int IDLE_LIMIT  = 2000;   // cycles without any transfer
  localparam int SETTLE_CYC  = 8;      // settle time after the last result
  localparam int RAND_ITEMS  = 400;
  localparam int HOLD_CYCLES = 300;    // long result-side hold-off

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
  } verdict_t;

  // mirror of the search: registers, stream state and pending verdicts
  class match_tracker;
    logic [PAT_W-1:0]  pat;
    logic [LEN_W-1:0]  len_reg;
    logic [WIN_W-1:0]  win_lo;
    logic [WIN_W-1:0]  win_hi;
    mode_e             mode;
    logic [BYTE_W-1:0] hist [PAT_BYTES];
    logic [16:0]       pos;
    logic              have;
    logic [IDX_W-1:0]  best;
    verdict_t          verdicts_due [$];
    int                errors;
    int                texts;
    int                hits;

    function new();
      pat     = '0;
      len_reg = LEN_W'(1);
      win_lo  = '0;
      win_hi  = '0;
      mode    = MODE_FIRST;
      errors  = 0;
      texts   = 0;
      hits    = 0;
      restart_text();
    endfunction

    function void restart_text();
      foreach (hist[k]) hist[k] = '0;
      pos  = '0;
      have = 1'b0;
      best = '0;
    endfunction

    // zero acts as one, anything above the cell count is clipped
    function int unsigned used_len();
      int unsigned n;
      n = len_reg;
      if (n == 0) n = 1;
      if (n > MAX_PATTERN_DEF) n = MAX_PATTERN_DEF;
      return n;
    endfunction

    function void take_reg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        REG_PATTERN_BYTES:  pat     = data;
        REG_PATTERN_LENGTH: len_reg = data[LEN_W-1:0];
        REG_SEARCH_BEGIN:   win_lo  = data[WIN_W-1:0];
        REG_SEARCH_END:     win_hi  = data[WIN_W-1:0];
        REG_SEARCH_MODE:    mode    = mode_e'(data[0]);
        default: ;
      endcase
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b, logic last);
      int unsigned n;
      int unsigned p;
      int unsigned s;
      int unsigned tlen;
      int          k;
      logic        hit;
      verdict_t    v;
      n = used_len();
      if (pos < MAX_TEXT_DEF) begin
        p = pos;
        for (k = PAT_BYTES - 1; k > 0; k--) hist[k] = hist[k-1];
        hist[0] = b;
        hit = (p + 1 >= n);
        for (k = 0; k < n; k++) begin
          if (hist[n-1-k] != pat[BYTE_W*k +: BYTE_W]) hit = 1'b0;
        end
        if (hit) begin
          s = p + 1 - n;
          if (mode == MODE_FIRST) begin
            if (!have && s >= win_lo && s < win_hi) begin
              have = 1'b1;
              best = IDX_W'(s);
            end
          end else if (p >= win_lo && p <= win_hi) begin
            have = 1'b1;
            best = IDX_W'(s);
          end
        end
        pos  = pos + 1'b1;
        tlen = pos;
      end else begin
        tlen = MAX_TEXT_DEF;
      end
      if (!last) return;
      v.found = have && (win_lo < tlen) && (win_hi < tlen) && (n <= tlen);
      v.index = v.found ? best : '0;
      texts++;
      if (v.found) hits++;
      verdicts_due.push_back(v);
      restart_text();
    endfunction

    function void check_verdict(logic found, logic [IDX_W-1:0] index);
      verdict_t v;
      if (verdicts_due.size() == 0) begin
        $display("%0t: result with nothing pending, found %0b index %0d", $time, found, index);
        errors++;
        return;
      end
      v = verdicts_due.pop_front();
      if (found !== v.found) begin
        $display("%0t: found expected %0b actual %0b", $time, v.found, found);
        errors++;
      end
      if (index !== v.index) begin
        $display("%0t: match_index expected %0d actual %0d", $time, v.index, index);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [BYTE_W-1:0]     s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [IDX_W-1:0]      m_axis_tdata;
  logic                  m_axis_tuser;

  match_tracker          tracker;
  logic [BYTE_W-1:0]     text_q [$];
  logic                  send_steady;   // no sender gaps in this phase
  logic                  recv_steady;   // no receiver stalls in this phase
  int                    hold_request;  // picked up by the result side
  int                    idle_cycles;
  int                    bytes_sent;
  int                    reg_writes;
  int                    phases;

  windowed_substring_search DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),    // [7:0] text_byte
    .s_axis_tlast (s_axis_tlast),    // is_last
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),    // [15:0] match_index
    .m_axis_tuser (m_axis_tuser)     // [0] found
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // watchdog: any transfer or register write counts as progress
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: check every transfer, then stall a random count
  initial begin : result_side
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.check_verdict(m_axis_tuser, m_axis_tdata);
        stall_left = recv_steady ? 0 : $urandom_range(0, 4);
      end
      // long hold-off, counted here so the sender keeps offering bytes
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // one register write, taken at the next rising edge
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    tracker.take_reg_write(addr, data);
    reg_writes++;
  endtask

  task automatic set_search(input logic [PAT_W-1:0] pat, input logic [LEN_W-1:0] n,
                            input logic [WIN_W-1:0] lo, input logic [WIN_W-1:0] hi,
                            input mode_e m);
    write_reg(REG_PATTERN_BYTES, pat);
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(n));
    write_reg(REG_SEARCH_BEGIN, CFG_DATA_W'(lo));
    write_reg(REG_SEARCH_END, CFG_DATA_W'(hi));
    write_reg(REG_SEARCH_MODE, CFG_DATA_W'(m));
    cfg_we_i <= 1'b0;
  endtask

  // random setting; upper data bits are noise the block must drop
  task automatic shuffle_config();
    logic [CFG_DATA_W-1:0] d;
    int                    k;
    if ($urandom_range(0, 2) != 0) begin
      d = {$urandom(), $urandom()};
      // two-letter alphabet gives overlapping matches
      if ($urandom_range(0, 1) == 1) begin
        for (k = 0; k < PAT_BYTES; k++) begin
          d[BYTE_W*k +: BYTE_W] = BYTE_W'($urandom_range(8'h61, 8'h62));
        end
      end
      write_reg(REG_PATTERN_BYTES, d);
    end
    if ($urandom_range(0, 2) != 0) begin
      d = {$urandom(), $urandom()};
      if ($urandom_range(0, 9) == 0) begin
        // lengths outside 1..8
        d[LEN_W-1:0] = ($urandom_range(0, 1) == 1) ? '0 : LEN_W'($urandom_range(9, 15));
      end else begin
        d[LEN_W-1:0] = LEN_W'($urandom_range(1, MAX_PATTERN_DEF));
      end
      write_reg(REG_PATTERN_LENGTH, d);
    end
    if ($urandom_range(0, 2) != 0) begin
      d = {$urandom(), $urandom()};
      d[WIN_W-1:0] = ($urandom_range(0, 7) == 0) ? '1 : WIN_W'($urandom_range(0, 10));
      write_reg(REG_SEARCH_BEGIN, d);
    end
    if ($urandom_range(0, 2) != 0) begin
      d = {$urandom(), $urandom()};
      d[WIN_W-1:0] = ($urandom_range(0, 7) == 0) ? '1 : WIN_W'($urandom_range(0, 20));
      write_reg(REG_SEARCH_END, d);
    end
    if ($urandom_range(0, 1) != 0) begin
      write_reg(REG_SEARCH_MODE, {$urandom(), $urandom()});
    end
    // indexes past the last register must be ignored
    if ($urandom_range(0, 4) == 0) begin
      write_reg(CFG_ADDR_W'($urandom_range(REG_SEARCH_MODE + 1, (1 << CFG_ADDR_W) - 1)),
                {$urandom(), $urandom()});
    end
    cfg_we_i <= 1'b0;
  endtask

  // random text: half the bytes from the pattern, plus planted copies
  task automatic make_text(input int len);
    int                n;
    int                i;
    int                k;
    int                at;
    logic [BYTE_W-1:0] b;
    n = tracker.used_len();
    text_q.delete();
    for (i = 0; i < len; i++) begin
      k = $urandom_range(0, n - 1);
      b = ($urandom_range(0, 1) == 1) ? tracker.pat[BYTE_W*k +: BYTE_W]
                                      : BYTE_W'($urandom_range(0, 255));
      text_q.push_back(b);
    end
    if (len >= n) begin
      repeat ($urandom_range(0, 2)) begin
        at = $urandom_range(0, len - n);
        for (k = 0; k < n; k++) text_q[at+k] = tracker.pat[BYTE_W*k +: BYTE_W];
      end
    end
  endtask

  task automatic load_text(input string s);
    text_q.delete();
    foreach (s[i]) text_q.push_back(s[i]);
  endtask

  task automatic fill_text(input logic [BYTE_W-1:0] b, input int len);
    text_q.delete();
    repeat (len) text_q.push_back(b);
  endtask

  // one byte transfer; called right after a rising edge
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.take_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) push_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // drain every pending verdict, then let the pipeline go quiet
  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    while (tracker.verdicts_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    phases++;
  endtask

  initial begin : stimulus
    int rand_start;
    tracker = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= '0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    send_steady  = 1'b0;
    recv_steady  = 1'b0;
    hold_request = 0;
    idle_cycles  = 0;
    bytes_sent   = 0;
    reg_writes   = 0;
    phases       = 0;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: window [0,0) is empty
    fill_text(8'h00, 1);
    send_text();
    finish_phase();

    // first mode, two matches, then a text shorter than the pattern
    set_search(64'h6261, 2, 0, 4, MODE_FIRST);
    load_text("xabab");
    send_text();
    load_text("a");
    send_text();
    finish_phase();

    // last mode, window on the final byte
    set_search(64'h6261, 2, 2, 4, MODE_LAST);
    load_text("ababa");
    send_text();
    finish_phase();

    // begin above end
    set_search(64'h6261, 2, 4, 2, MODE_FIRST);
    load_text("ababa");
    send_text();
    finish_phase();

    // all-ones pattern, length 15 acts as the full eight bytes
    set_search('1, 15, 0, 1, MODE_FIRST);
    fill_text(8'hFF, 8);
    send_text();
    finish_phase();

    // length zero acts as one
    set_search('0, 0, 0, 0, MODE_LAST);
    fill_text(8'h00, 2);
    text_q.push_back(8'h05);
    send_text();
    finish_phase();

    // random settings and texts
    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RAND_ITEMS) begin
      shuffle_config();
      send_steady = ($urandom_range(0, 3) == 0);
      recv_steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 8)) begin
        make_text(($urandom_range(0, 5) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16));
        send_text();
      end
      finish_phase();

      // once: hold the result side while short texts keep coming
      if (phases == 7) begin
        send_steady  = 1'b1;
        recv_steady  = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (30) begin
          make_text($urandom_range(1, 3));
          send_text();
        end
        finish_phase();
      end
    end

    $display("covered %0d texts (%0d with a match), %0d bytes, %0d register writes, %0d phases",
             tracker.texts, tracker.hits, bytes_sent, reg_writes, phases);
    $display("both modes, lengths 0 to 15, empty and out-of-range windows, a long result hold");
    if (tracker.verdicts_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, tracker.verdicts_due.size());
      tracker.errors += tracker.verdicts_due.size();
    end
    if (tracker.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
